>>> src/tcw_pkg.sv
package tcw_pkg;

    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int FIELD_W = 11;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h07;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    localparam logic KIND_PRINT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // register index as seen in paddr[2]
    localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_READ_DONE,
        OP_CLEAR,
        OP_COPY,
        OP_FILL
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic out_full;
        logic scroll;
        logic cnt_copy_end;
        logic cnt_end;
    } status_t;

endpackage

>>> src/tcw_ctrl.sv
module tcw_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tuser,
    input  logic             m_tready,
    input  tcw_pkg::status_t status,
    output tcw_pkg::cmd_t    cmd
);
    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (status.cnt_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // take an item once the output register is free or being drained
                s_tready = !status.out_full || m_tready;
                if (s_tvalid && s_tready) begin
                    cmd.op = OP_ACCEPT;
                    if (s_tuser == KIND_READ) begin
                        state_next = ST_READ;
                    end else if (status.scroll) begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_READ: begin
                cmd.op     = OP_READ_DONE;
                state_next = ST_IDLE;
            end
            ST_COPY: begin
                cmd.op = OP_COPY;
                if (status.cnt_copy_end) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.op = OP_FILL;
                if (status.cnt_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/tcw_datapath.sv
module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tcw_pkg::cmd_t    cmd,
    output tcw_pkg::status_t status,
    input  logic [23:0]      s_tdata,
    input  logic             s_tuser,
    input  logic [7:0]       text_attr,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int N_COPY     = (ROWS - 1) * COLUMNS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    logic [15:0] mem [CELL_COUNT];
    logic [15:0] rdata_reg;

    logic [CELL_W-1:0] cnt_reg, cnt_next;
    logic [CELL_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] out_cursor_reg, out_cursor_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [ATTR_W-1:0] out_attr_reg, out_attr_next;
    logic              in_range_reg, in_range_next;

    logic              wr_en;
    logic [CELL_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic [CELL_W-1:0] rd_addr;

    logic [CHAR_W-1:0]  code;
    logic [FIELD_W-1:0] idx;
    logic               is_nl;
    logic               wrap_col;
    logic               last_row;

    assign code     = s_tdata[7:0];
    assign idx      = s_tdata[18:8];
    assign is_nl    = (code == NEWLINE_CODE);
    assign wrap_col = (col_reg == COL_W'(COLUMNS - 1));
    assign last_row = (row_reg == ROW_W'(ROWS - 1));

    assign status.out_full     = out_valid_reg;
    assign status.scroll       = (s_tuser == KIND_PRINT) && (is_nl || wrap_col) && last_row;
    assign status.cnt_copy_end = (cnt_reg == CELL_W'(N_COPY));
    assign status.cnt_end      = (cnt_reg == CELL_W'(CELL_COUNT - 1));

    always_comb begin
        cnt_next        = cnt_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_cursor_next = out_cursor_reg;
        out_char_next   = out_char_reg;
        out_attr_next   = out_attr_reg;
        in_range_next   = in_range_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg;
        wr_data         = {BLANK_ATTR, SPACE_CODE};
        rd_addr         = CELL_W'(idx);
        unique case (cmd.op)
            OP_ACCEPT: begin
                cnt_next = '0;
                if (s_tuser == KIND_PRINT) begin
                    if (!is_nl) begin
                        wr_en   = 1'b1;
                        wr_addr = cursor_reg;
                        wr_data = {text_attr, code};
                    end
                    if (status.scroll) begin
                        cursor_next = CELL_W'(N_COPY);
                        row_next    = ROW_W'(ROWS - 1);
                        col_next    = '0;
                    end else if (is_nl) begin
                        cursor_next = cursor_reg - CELL_W'(col_reg) + CELL_W'(COLUMNS);
                        row_next    = row_reg + ROW_W'(1);
                        col_next    = '0;
                    end else begin
                        cursor_next = cursor_reg + CELL_W'(1);
                        if (wrap_col) begin
                            col_next = '0;
                            row_next = row_reg + ROW_W'(1);
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                    out_valid_next  = 1'b1;
                    out_cursor_next = FIELD_W'(cursor_next);
                    out_char_next   = '0;
                    out_attr_next   = '0;
                end else begin
                    in_range_next = ({21'b0, idx} < 32'(CELL_COUNT));
                end
            end
            OP_READ_DONE: begin
                out_valid_next  = 1'b1;
                out_cursor_next = FIELD_W'(cursor_reg);
                out_char_next   = in_range_reg ? rdata_reg[7:0] : '0;
                out_attr_next   = in_range_reg ? rdata_reg[15:8] : '0;
            end
            OP_CLEAR, OP_FILL: begin
                wr_en = 1'b1;
                if (!status.cnt_end) begin
                    cnt_next = cnt_reg + CELL_W'(1);
                end
            end
            OP_COPY: begin
                // read one row below, write the word fetched last cycle one cell back
                if (!status.cnt_copy_end) begin
                    rd_addr  = cnt_reg + CELL_W'(COLUMNS);
                    cnt_next = cnt_reg + CELL_W'(1);
                end
                if (cnt_reg != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = cnt_reg - CELL_W'(1);
                    wr_data = rdata_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            cursor_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_cursor_reg <= out_cursor_next;
        out_char_reg   <= out_char_next;
        out_attr_reg   <= out_attr_next;
        in_range_reg   <= in_range_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_attr_reg, out_char_reg, out_cursor_reg};

endmodule

>>> src/text_console_char_writer_top.sv
// Print item without scroll: result registered on accept; next item taken once the output register is free or drained.
// Read item: the result is registered after the registered screen memory read (ST_READ).
// Print that scrolls: row copy (ST_COPY) and bottom-row fill (ST_FILL) run before
// the next item is taken; the result is registered at once.
// Reset (aresetn low, synchronous) clears control state, then a pass over all ROWS*COLUMNS
// cells blanks the screen memory while no item is taken; text_attribute resets to 0x07.
module text_console_char_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8]
    input  logic        s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cursor_cell[10:0], read_char[18:11], read_attr[26:19]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    cmd_t              cmd;
    status_t           status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTRIBUTE) begin
            attr_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_TEXT_ATTRIBUTE) ? {24'b0, attr_reg} : 32'b0;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .text_attr (attr_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
